// File: sv/efws_pkg.sv
// Shared constants and types for the earliest-free worker scheduler.
// No dependencies; imported by efws_mem and the top level.
`default_nettype none

package efws_pkg;

  localparam int MAX_WORKERS_DEF = 64;  // default heap depth
  localparam int TIME_BITS_DEF   = 48;  // default width of a free time
  localparam int DUR_W           = 32;  // job duration port width
  localparam int ID_OUT_W        = 6;   // worker_id port width
  localparam int START_W         = 48;  // start_tick port width
  localparam int CNT_W           = 7;   // worker_count register width

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a job
    S_ROOT,   // root read back, add duration, issue child reads
    S_PICK,   // pick smaller child
    S_MOVE    // compare child against the sifted entry
  } state_t;

  // heap memory control from the sequencer
  typedef struct packed {
    logic clear;  // invalidate all slots (back to reset contents)
    logic wr_en;  // write one slot
  } mem_ctl_t;

endpackage

`default_nettype wire

// File: sv/efws_cmp.sv
// Shared (time, id) compare unit of the scheduler heap.
// Depends on nothing but its parameters.
`default_nettype none

module efws_cmp #(
  parameter int TW = 48,
  parameter int IW = 6
) (
  input  wire logic [TW-1:0] a_time,
  input  wire logic [IW-1:0] a_id,
  input  wire logic [TW-1:0] b_time,
  input  wire logic [IW-1:0] b_id,
  output logic               a_less
);

  // strict (time, id) order; ids are unique so it is total
  assign a_less = (a_time < b_time) || ((a_time == b_time) && (a_id < b_id));

endmodule

`default_nettype wire

// File: sv/efws_mem.sv
// Heap slot memory: one write port, two registered read ports, per-slot valid bits.
// An invalid slot reads as its reset contents: time 0, id equal to the slot index.
// Uses efws_pkg for the control struct.
`default_nettype none

module efws_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int TW    = 48
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire efws_pkg::mem_ctl_t  ctl,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [TW-1:0]       wr_time,
  input  wire logic [AW-1:0]       wr_id,
  input  wire logic [AW-1:0]       rd_addr_a,
  input  wire logic [AW-1:0]       rd_addr_b,
  output logic      [TW-1:0]       rd_time_a,
  output logic      [AW-1:0]       rd_id_a,
  output logic      [TW-1:0]       rd_time_b,
  output logic      [AW-1:0]       rd_id_b
);
  import efws_pkg::*;

  logic [TW+AW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  logic [TW+AW-1:0] q_a;
  logic [TW+AW-1:0] q_b;
  logic             q_valid_a;
  logic             q_valid_b;
  logic [AW-1:0]    q_addr_a;
  logic [AW-1:0]    q_addr_b;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_time, wr_id};
    end
    q_a      <= mem[rd_addr_a];
    q_b      <= mem[rd_addr_b];
    q_addr_a <= rd_addr_a;
    q_addr_b <= rd_addr_b;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid     <= '0;
      q_valid_a <= 1'b0;
      q_valid_b <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      q_valid_a <= valid[rd_addr_a];
      q_valid_b <= valid[rd_addr_b];
    end
  end

  always_comb begin
    if (q_valid_a) begin
      {rd_time_a, rd_id_a} = q_a;
    end else begin
      rd_time_a = '0;
      rd_id_a   = q_addr_a;
    end
    if (q_valid_b) begin
      {rd_time_b, rd_id_b} = q_b;
    end else begin
      rd_time_b = '0;
      rd_id_b   = q_addr_b;
    end
  end

endmodule

`default_nettype wire

// File: sv/earliest_free_worker_scheduler.sv
// Earliest-free worker scheduler: top level with the sift sequencer.
// Depends on efws_pkg, efws_mem (heap slots) and efws_cmp (shared compare unit).
//
//  channel   ports                                     handshake
//  -------   ----------------------------------------  ------------------------------
//  job in    duration                                  start && !busy accepts
//  result    worker_id, start_tick, time_saturated     done high for one cycle
//  config    cfg_wdata (worker_count)                  cfg_we, written at once
//
// A job is taken in an idle cycle; the next cycle reads the root, adds the duration and
// registers the result, and done is high the cycle after that. The sift then descends one
// level per child pick followed by a compare with the sifted entry (one compare unit), and
// retires at a slot with no children or where the sifted entry is not larger than the
// smaller child. 64 slots make 7 levels; a new job is not taken while busy. Reset or a
// worker_count write returns every slot to its reset contents; the receiver cannot stall.
`default_nettype none

module earliest_free_worker_scheduler #(
  parameter int MAX_WORKERS = efws_pkg::MAX_WORKERS_DEF,
  parameter int TIME_BITS   = efws_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [efws_pkg::DUR_W-1:0]    duration,
  output logic                               done,
  output logic      [efws_pkg::ID_OUT_W-1:0] worker_id,
  output logic      [efws_pkg::START_W-1:0]  start_tick,
  output logic                               time_saturated,
  input  wire logic                          cfg_we,
  input  wire logic [efws_pkg::CNT_W-1:0]    cfg_wdata
);
  import efws_pkg::*;

  localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;  // slot index
  localparam int CW = $clog2(MAX_WORKERS + 1);                      // heap size
  localparam int XW = AW + 2;                                       // child index
  localparam int TW = TIME_BITS;

  state_t state, state_next;

  // sequencer registers
  logic [CW-1:0]   heap_size;
  logic [CW-1:0]   cnt_clamped;
  logic [DUR_W-1:0] dur;
  logic [AW-1:0]   pos, pos_next;
  logic [TW-1:0]   x_time;      // entry being sifted down
  logic [AW-1:0]   x_id;
  logic [TW-1:0]   best_time;   // smaller child
  logic [AW-1:0]   best_id;
  logic [AW-1:0]   best_idx;

  // memory side
  mem_ctl_t        mctl;
  logic [AW-1:0]   wr_addr;
  logic [TW-1:0]   wr_time;
  logic [AW-1:0]   wr_id;
  logic            wr_sel_best;
  logic [AW-1:0]   rd_addr_a, rd_addr_b;
  logic [TW-1:0]   rd_time_a, rd_time_b;
  logic [AW-1:0]   rd_id_a, rd_id_b;

  // compare unit operands
  logic [TW-1:0]   ca_time, cb_time;
  logic [AW-1:0]   ca_id, cb_id;
  logic            a_less;

  // children of the current position and of the chosen child
  logic [XW-1:0]   pos_left, pos_right, best_left, best_right;
  logic            left_ok, right_ok;

  // root update
  logic [TW:0]     sum;
  logic            sat;
  logic [TW-1:0]   new_time;

  efws_mem #(
    .DEPTH (MAX_WORKERS),
    .AW    (AW),
    .TW    (TW)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mctl),
    .wr_addr   (wr_addr),
    .wr_time   (wr_time),
    .wr_id     (wr_id),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_time_a (rd_time_a),
    .rd_id_a   (rd_id_a),
    .rd_time_b (rd_time_b),
    .rd_id_b   (rd_id_b)
  );

  efws_cmp #(
    .TW (TW),
    .IW (AW)
  ) u_cmp (
    .a_time (ca_time),
    .a_id   (ca_id),
    .b_time (cb_time),
    .b_id   (cb_id),
    .a_less (a_less)
  );

  // worker_count write: zero reads as one, large values clip to the build size
  always_comb begin
    if (cfg_wdata == '0) begin
      cnt_clamped = CW'(1);
    end else if (32'(cfg_wdata) > MAX_WORKERS) begin
      cnt_clamped = CW'(MAX_WORKERS);
    end else begin
      cnt_clamped = CW'(cfg_wdata);
    end
  end

  assign pos_left   = {1'b0, pos, 1'b1};
  assign pos_right  = pos_left + XW'(1);
  assign best_left  = {1'b0, best_idx, 1'b1};
  assign best_right = best_left + XW'(1);
  assign left_ok    = pos_left  < XW'(heap_size);
  assign right_ok   = pos_right < XW'(heap_size);

  // saturating add of the job onto the root's free time
  assign sum      = {1'b0, rd_time_a} + (TW+1)'(dur);
  assign sat      = sum[TW];
  assign new_time = sat ? '1 : sum[TW-1:0];

  assign wr_addr = pos;
  assign wr_time = wr_sel_best ? best_time : x_time;
  assign wr_id   = wr_sel_best ? best_id   : x_id;
  assign busy    = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory addresses, compare operands
  always_comb begin
    state_next  = state;
    pos_next    = pos;
    mctl.clear  = cfg_we;
    mctl.wr_en  = 1'b0;
    wr_sel_best = 1'b0;
    rd_addr_a   = '0;
    rd_addr_b   = '0;
    ca_time     = rd_time_b;
    ca_id       = rd_id_b;
    cb_time     = rd_time_a;
    cb_id       = rd_id_a;
    case (state)
      S_IDLE: begin
        // root read is always in flight while idle
        pos_next = '0;
        if (start) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        rd_addr_a  = pos_left[AW-1:0];
        rd_addr_b  = pos_right[AW-1:0];
        state_next = S_PICK;
      end
      S_PICK: begin
        // compare right child against left child
        if (!left_ok) begin
          mctl.wr_en = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        // compare chosen child against the sifted entry
        ca_time = best_time;
        ca_id   = best_id;
        cb_time = x_time;
        cb_id   = x_id;
        mctl.wr_en = 1'b1;
        if (a_less) begin
          wr_sel_best = 1'b1;
          pos_next    = best_idx;
          rd_addr_a   = best_left[AW-1:0];
          rd_addr_b   = best_right[AW-1:0];
          state_next  = S_PICK;
        end else begin
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size <= CW'(1);
      done      <= 1'b0;
      pos       <= '0;
    end else begin
      if (cfg_we) begin
        heap_size <= cnt_clamped;
      end
      done <= (state == S_ROOT);
      pos  <= pos_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      dur <= duration;
    end
    if (state == S_ROOT) begin
      x_time         <= new_time;
      x_id           <= rd_id_a;
      worker_id      <= ID_OUT_W'(rd_id_a);
      start_tick     <= START_W'(rd_time_a);
      time_saturated <= sat;
    end
    if (state == S_PICK) begin
      if (right_ok && a_less) begin
        best_time <= rd_time_b;
        best_id   <= rd_id_b;
        best_idx  <= pos_right[AW-1:0];
      end else begin
        best_time <= rd_time_a;
        best_id   <= rd_id_a;
        best_idx  <= pos_left[AW-1:0];
      end
    end
  end

endmodule

`default_nettype wire
